@@ rtl/burst_request_splitter_assert.svh @@
// Assertion macros for the burst request splitter back end.
// Each module that includes this file must have clk and rst_n in scope.
`ifndef BURST_REQUEST_SPLITTER_ASSERT_SVH
`define BURST_REQUEST_SPLITTER_ASSERT_SVH

// Same-cycle implication, checked only outside reset.
`define BRS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked only outside reset.
`define BRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/brs_pkg.sv @@
// Package for the burst request splitter: block size constants, the
// command record passed from front to back, and queue status.
// No dependencies.
package brs_pkg;

  localparam int unsigned BURST_BYTES = 64;
  localparam int unsigned OFFS_W      = $clog2(BURST_BYTES);
  localparam int unsigned MAX_REQS    = 64;
  localparam int unsigned IDX_W       = $clog2(MAX_REQS);
  localparam int unsigned LEN_W       = 12;
  // Holds offset + length + (block size - 1) for block sizes up to 1024.
  localparam int unsigned SPAN_W      = LEN_W + 1;
  localparam int unsigned BLK_W       = SPAN_W - OFFS_W;
  localparam int unsigned QDEPTH      = 4;
  localparam int unsigned QPTR_W      = $clog2(QDEPTH);

  localparam logic [31:0] ADDR_STEP   = 32'(BURST_BYTES);
  localparam logic [31:0] OFFS_MASK   = 32'(BURST_BYTES - 1);

  typedef struct packed {
    logic             access_type;
    logic [31:0]      base_addr;
    logic [IDX_W-1:0] last_idx;
    logic [31:0]      burst_index;
    logic [7:0]       engine_index;
  } brs_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } brs_qstat_t;

endpackage

@@ rtl/brs_front.sv @@
// Front end of the burst request splitter: accepts bursts, drops empty
// ones, and turns the rest into commands for the queue. Uses brs_pkg.
module brs_front import brs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  logic              in_access_type,
  input  logic [31:0]       in_start_addr,
  input  logic [LEN_W-1:0]  in_byte_count,
  input  logic [31:0]       in_burst_index,
  input  logic [7:0]        in_engine_index,
  output logic              q_push,
  output brs_cmd_t          q_wdata,
  input  brs_qstat_t        q_stat
);

  logic              f_vld_r, f_vld_nxt;
  brs_cmd_t          f_cmd_r, f_cmd_nxt;
  logic              accept;
  logic              nonzero;
  logic [SPAN_W-1:0] span;
  logic [BLK_W-1:0]  blocks;

  assign full    = f_vld_r && q_stat.full;
  assign accept  = push && !full;
  assign q_push  = f_vld_r && !q_stat.full;
  assign q_wdata = f_cmd_r;
  assign nonzero = (in_byte_count != '0);

  // Number of blocks touched: (offset + length + block size - 1) / block size.
  assign span   = SPAN_W'(in_start_addr & OFFS_MASK) + SPAN_W'(in_byte_count)
                + SPAN_W'(OFFS_MASK);
  assign blocks = BLK_W'(span >> OFFS_W);

  always_comb begin
    f_cmd_nxt.access_type  = in_access_type;
    f_cmd_nxt.base_addr    = in_start_addr & ~OFFS_MASK;
    f_cmd_nxt.burst_index  = in_burst_index;
    f_cmd_nxt.engine_index = in_engine_index;
    if (32'(blocks) > 32'(MAX_REQS)) begin
      f_cmd_nxt.last_idx = IDX_W'(MAX_REQS - 1);
    end else begin
      f_cmd_nxt.last_idx = IDX_W'(blocks - BLK_W'(1));
    end
  end

  always_comb begin
    f_vld_nxt = f_vld_r;
    if (accept && nonzero) begin
      f_vld_nxt = 1'b1;
    end else if (q_push) begin
      f_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else begin
      f_vld_r <= f_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && nonzero) begin
      f_cmd_r <= f_cmd_nxt;
    end
  end

endmodule

@@ rtl/brs_cmd_fifo.sv @@
// Short command queue between the front and back ends of the burst
// request splitter. Uses brs_pkg for depth and the command record.
module brs_cmd_fifo import brs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       wr_en,
  input  brs_cmd_t   wr_data,
  input  logic       rd_en,
  output brs_cmd_t   rd_data,
  output brs_qstat_t stat
);

  brs_cmd_t          mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;

  assign stat.full  = (cnt_r == (QPTR_W + 1)'(QDEPTH));
  assign stat.empty = (cnt_r == '0);
  assign rd_data    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_en ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = rd_en ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + (QPTR_W + 1)'(1);
    end else if (rd_en && !wr_en) begin
      cnt_nxt = cnt_r - (QPTR_W + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

@@ rtl/brs_back.sv @@
// Back end of the burst request splitter: walks one command block by
// block and fills the result register. Uses brs_pkg and the assert macros.
`include "burst_request_splitter_assert.svh"

module brs_back import brs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  brs_cmd_t    q_rdata,
  input  brs_qstat_t  q_stat,
  output logic        q_pop,
  input  logic        pop,
  output logic        empty,
  output logic        out_req_type,
  output logic [31:0] out_req_addr,
  output logic [31:0] out_req_burst_index,
  output logic [31:0] out_req_sequence,
  output logic [7:0]  out_req_engine_index,
  output logic        out_last_of_burst
);

  logic             b_vld_r, b_vld_nxt;
  brs_cmd_t         b_cmd_r, b_cmd_nxt;
  logic [IDX_W-1:0] k_r, k_nxt;
  logic [31:0]      addr_r, addr_nxt;
  logic [31:0]      seq_r, seq_nxt;
  logic             out_vld_r, out_vld_nxt;
  logic             out_pop;
  logic             out_free;
  logic             gen;
  logic             last;
  logic             take;

  assign empty    = !out_vld_r;
  assign out_pop  = pop && out_vld_r;
  assign out_free = !out_vld_r || out_pop;
  assign gen      = b_vld_r && out_free;
  assign last     = (k_r == b_cmd_r.last_idx);
  // A new command is taken from the queue, if one waits, when the walker is idle or finishing this cycle.
  assign take     = !b_vld_r || (gen && last);
  assign q_pop    = take && !q_stat.empty;

  always_comb begin
    b_vld_nxt   = b_vld_r;
    b_cmd_nxt   = b_cmd_r;
    k_nxt       = k_r;
    addr_nxt    = addr_r;
    seq_nxt     = gen ? seq_r + 32'd1 : seq_r;
    out_vld_nxt = out_vld_r;
    if (q_pop) begin
      b_vld_nxt = 1'b1;
      b_cmd_nxt = q_rdata;
      k_nxt     = '0;
      addr_nxt  = q_rdata.base_addr;
    end else if (gen) begin
      b_vld_nxt = !last;
      k_nxt     = k_r + IDX_W'(1);
      addr_nxt  = addr_r + ADDR_STEP;
    end
    if (gen) begin
      out_vld_nxt = 1'b1;
    end else if (out_pop) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r   <= 1'b0;
      k_r       <= '0;
      seq_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      b_vld_r   <= b_vld_nxt;
      k_r       <= k_nxt;
      seq_r     <= seq_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    b_cmd_r <= b_cmd_nxt;
    addr_r  <= addr_nxt;
    if (gen) begin
      out_req_type         <= b_cmd_r.access_type;
      out_req_addr         <= addr_r;
      out_req_burst_index  <= b_cmd_r.burst_index;
      out_req_sequence     <= seq_r;
      out_req_engine_index <= b_cmd_r.engine_index;
      out_last_of_burst    <= last;
    end
  end

  `BRS_ASSERT_NEXT(a_seq_step, gen, seq_r == $past(seq_r) + 32'd1,
                   "sequence number did not advance by one per request")
  `BRS_ASSERT_NEXT(a_addr_step, gen && !last,
                   addr_r == $past(addr_r) + ADDR_STEP,
                   "request address did not advance by one block")
  `BRS_ASSERT_NEXT(a_walk_done, gen && last && !q_pop, !b_vld_r,
                   "walker stayed busy after the last request of a burst")
  `BRS_ASSERT_SAME(a_idx_range, b_vld_r, k_r <= b_cmd_r.last_idx,
                   "block index ran past the end of the burst")

endmodule

@@ rtl/burst_request_splitter.sv @@
// Burst request splitter: a burst goes through the front register, the command
// queue and the walker to the result register, then one request per cycle
// while results are popped. A burst of N blocks keeps the walker busy for N
// requests (N at most 64); zero-length bursts are dropped. The front accepts
// one burst per cycle while the four-entry command queue has room. Reset
// (rst_n low, synchronous) empties everything and zeroes the counter.
module burst_request_splitter import brs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  // Burst input channel.
  input  logic              push,
  output logic              full,
  input  logic              in_access_type,
  input  logic [31:0]       in_start_addr,
  input  logic [LEN_W-1:0]  in_byte_count,
  input  logic [31:0]       in_burst_index,
  input  logic [7:0]        in_engine_index,
  // Request output channel.
  input  logic              pop,
  output logic              empty,
  output logic              out_req_type,
  output logic [31:0]       out_req_addr,
  output logic [31:0]       out_req_burst_index,
  output logic [31:0]       out_req_sequence,
  output logic [7:0]        out_req_engine_index,
  output logic              out_last_of_burst
);

  // The front stage classifies each burst: it drops bursts of zero length
  // and computes the aligned-down base address and the index of the last
  // block, clamped so that no burst produces more than 64 requests.
  brs_cmd_t   q_wdata;
  brs_cmd_t   q_rdata;
  brs_qstat_t q_stat;
  logic       q_push;
  logic       q_pop;

  brs_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_access_type  (in_access_type),
    .in_start_addr   (in_start_addr),
    .in_byte_count   (in_byte_count),
    .in_burst_index  (in_burst_index),
    .in_engine_index (in_engine_index),
    .q_push          (q_push),
    .q_wdata         (q_wdata),
    .q_stat          (q_stat)
  );

  // The command queue lets the front keep taking bursts while the back end
  // is still walking a long one.
  brs_cmd_fifo u_cmd_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_data (q_wdata),
    .rd_en   (q_pop),
    .rd_data (q_rdata),
    .stat    (q_stat)
  );

  // The back end emits one request per block, stamps each with the running
  // request number, and flags the final one. Its result register holds the
  // current request, and the walker advances only when it is empty or popped.
  brs_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .q_rdata              (q_rdata),
    .q_stat               (q_stat),
    .q_pop                (q_pop),
    .pop                  (pop),
    .empty                (empty),
    .out_req_type         (out_req_type),
    .out_req_addr         (out_req_addr),
    .out_req_burst_index  (out_req_burst_index),
    .out_req_sequence     (out_req_sequence),
    .out_req_engine_index (out_req_engine_index),
    .out_last_of_burst    (out_last_of_burst)
  );

endmodule
